@@ design/cep_pkg.sv @@
// Package for the chunked executable parser: payload types, result codes,
// file-format constants and the request passed to the size-rounding unit.
// No dependencies; every other design file uses it.
`default_nettype none

package cep_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_ALIGN_DEF = 2048;

  localparam logic [31:0] FILE_MAGIC = 32'h0145_5043;
  localparam logic [15:0] REG_CODE_PC = 16'h0090;
  localparam logic [31:0] STACK_TOP = 32'h801F_FFF0;

  localparam logic [7:0] CHUNK_END = 8'h00;
  localparam logic [7:0] CHUNK_LOAD = 8'h01;
  localparam logic [7:0] CHUNK_REG = 8'h03;
  localparam logic [7:0] CHUNK_UNIT = 8'h08;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MAGIC      = 2'd0,
    ERR_REG_CODE   = 2'd1,
    ERR_CHUNK_TYPE = 2'd2
  } err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic [31:0] entry_point;
    logic [31:0] load_base;
    logic [31:0] load_size;
    logic [31:0] stack_address;
    err_t        error_code;
  } out_item_t;

  // Summary request from the parser to the rounding unit.
  typedef struct packed {
    logic        start;
    logic [31:0] size_total;
    logic [31:0] entry_point;
    logic [31:0] load_base;
  } sum_req_t;

endpackage

`default_nettype wire

@@ design/cep_in_if.sv @@
// Input stream interface: valid/ready handshake carrying one file byte.
// Depends on cep_pkg for the payload type.
`default_nettype none

interface cep_in_if;
  logic              valid;
  logic              ready;
  cep_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/cep_out_if.sv @@
// Output stream interface: valid/ready handshake carrying one result.
// Depends on cep_pkg for the payload type.
`default_nettype none

interface cep_out_if;
  logic               valid;
  logic               ready;
  cep_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/cep_parser.sv @@
// Byte-serial chunk parser: phase state machine, field assembly and the
// per-file accumulators. Depends on cep_pkg.
`default_nettype none

module cep_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  cep_pkg::in_item_t   item,
  output logic                res_valid,
  output cep_pkg::out_item_t  res,
  output cep_pkg::sum_req_t   sum_req
);
  import cep_pkg::*;

  typedef enum logic [8:0] {
    PH_MAGIC   = 9'b0_0000_0001,
    PH_TYPE    = 9'b0_0000_0010,
    PH_ADDR    = 9'b0_0000_0100,
    PH_LEN     = 9'b0_0000_1000,
    PH_DATA    = 9'b0_0001_0000,
    PH_REGCODE = 9'b0_0010_0000,
    PH_REGVAL  = 9'b0_0100_0000,
    PH_UNIT    = 9'b0_1000_0000,
    PH_HALT    = 9'b1_0000_0000
  } phase_t;

  phase_t      phase, phase_e, phase_next;
  logic [2:0]  cnt, cnt_e, cnt_next, cnt_inc;
  logic [31:0] chunk_address, chunk_address_e, chunk_address_next;
  logic [31:0] bytes_remaining, bytes_remaining_e, bytes_remaining_next;
  logic [31:0] entry_value, entry_value_e, entry_value_next;
  logic [31:0] lowest_address, lowest_address_e, lowest_address_next;
  logic        any_chunk_seen, any_chunk_seen_e, any_chunk_seen_next;
  logic [31:0] size_total, size_total_e, size_total_next;
  logic [31:0] magic_shift, magic_shift_e, magic_shift_next;
  logic [15:0] register_code, register_code_e, register_code_next;
  logic [7:0]  b;
  logic [31:0] addr_sh, len_sh, entry_sh, magic_sh;
  logic [15:0] code_sh;
  logic        emit, launch;

  assign b = item.in_byte;

  // A start mark clears the whole parse state before this byte is used.
  always_comb begin
    if (item.start_of_file) begin
      phase_e           = PH_MAGIC;
      cnt_e             = '0;
      chunk_address_e   = '0;
      bytes_remaining_e = '0;
      entry_value_e     = '0;
      lowest_address_e  = '0;
      any_chunk_seen_e  = 1'b0;
      size_total_e      = '0;
      magic_shift_e     = '0;
      register_code_e   = '0;
    end else begin
      phase_e           = phase;
      cnt_e             = cnt;
      chunk_address_e   = chunk_address;
      bytes_remaining_e = bytes_remaining;
      entry_value_e     = entry_value;
      lowest_address_e  = lowest_address;
      any_chunk_seen_e  = any_chunk_seen;
      size_total_e      = size_total;
      magic_shift_e     = magic_shift;
      register_code_e   = register_code;
    end
  end

  // Fields arrive least significant byte first.
  assign cnt_inc  = cnt_e + 3'd1;
  assign magic_sh = {b, magic_shift_e[31:8]};
  assign addr_sh  = {b, chunk_address_e[31:8]};
  assign len_sh   = {b, bytes_remaining_e[31:8]};
  assign entry_sh = {b, entry_value_e[31:8]};
  assign code_sh  = {b, register_code_e[15:8]};

  always_comb begin
    phase_next           = phase_e;
    cnt_next             = cnt_e;
    chunk_address_next   = chunk_address_e;
    bytes_remaining_next = bytes_remaining_e;
    entry_value_next     = entry_value_e;
    lowest_address_next  = lowest_address_e;
    any_chunk_seen_next  = any_chunk_seen_e;
    size_total_next      = size_total_e;
    magic_shift_next     = magic_shift_e;
    register_code_next   = register_code_e;
    emit                 = 1'b0;
    launch               = 1'b0;
    res                  = '0;

    unique case (phase_e)
      PH_MAGIC: begin
        magic_shift_next = magic_sh;
        cnt_next = cnt_inc;
        if (cnt_e == 3'd3) begin
          cnt_next = '0;
          if (magic_sh != FILE_MAGIC) begin
            emit = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_MAGIC;
            phase_next = PH_HALT;
          end else begin
            phase_next = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        cnt_next = '0;
        case (b)
          CHUNK_END: begin
            launch = 1'b1;
            phase_next = PH_HALT;
          end
          CHUNK_LOAD: phase_next = PH_ADDR;
          CHUNK_REG: begin
            phase_next = PH_REGCODE;
            register_code_next = '0;
          end
          CHUNK_UNIT: phase_next = PH_UNIT;
          default: begin
            emit = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_CHUNK_TYPE;
            phase_next = PH_HALT;
          end
        endcase
      end
      PH_ADDR: begin
        chunk_address_next = addr_sh;
        cnt_next = cnt_inc;
        if (cnt_e == 3'd3) begin
          cnt_next = '0;
          if (!any_chunk_seen_e || addr_sh < lowest_address_e) begin
            lowest_address_next = addr_sh;
          end
          any_chunk_seen_next = 1'b1;
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        bytes_remaining_next = len_sh;
        cnt_next = cnt_inc;
        if (cnt_e == 3'd3) begin
          cnt_next = '0;
          size_total_next = size_total_e + len_sh;
          phase_next = (len_sh == '0) ? PH_TYPE : PH_DATA;
        end
      end
      PH_DATA: begin
        emit = 1'b1;
        res.kind = KIND_DATA;
        res.data_byte = b;
        res.byte_address = chunk_address_e;
        chunk_address_next = chunk_address_e + 32'd1;
        bytes_remaining_next = bytes_remaining_e - 32'd1;
        if (bytes_remaining_e == 32'd1) begin
          phase_next = PH_TYPE;
        end
      end
      PH_REGCODE: begin
        register_code_next = code_sh;
        cnt_next = cnt_inc;
        if (cnt_e == 3'd1) begin
          cnt_next = '0;
          if (code_sh != REG_CODE_PC) begin
            emit = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_REG_CODE;
            phase_next = PH_HALT;
          end else begin
            phase_next = PH_REGVAL;
          end
        end
      end
      PH_REGVAL: begin
        entry_value_next = entry_sh;
        cnt_next = cnt_inc;
        if (cnt_e == 3'd3) begin
          cnt_next = '0;
          phase_next = PH_TYPE;
        end
      end
      PH_UNIT: phase_next = PH_TYPE;
      PH_HALT: phase_next = PH_HALT;
      default: phase_next = PH_HALT;
    endcase
  end

  assign res_valid           = step && emit;
  assign sum_req.start       = step && launch;
  assign sum_req.size_total  = size_total_e;
  assign sum_req.entry_point = entry_value_e;
  assign sum_req.load_base   = any_chunk_seen_e ? lowest_address_e : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC;
      cnt             <= '0;
      chunk_address   <= '0;
      bytes_remaining <= '0;
      entry_value     <= '0;
      lowest_address  <= '0;
      any_chunk_seen  <= 1'b0;
      size_total      <= '0;
      magic_shift     <= '0;
      register_code   <= '0;
    end else if (step) begin
      phase           <= phase_next;
      cnt             <= cnt_next;
      chunk_address   <= chunk_address_next;
      bytes_remaining <= bytes_remaining_next;
      entry_value     <= entry_value_next;
      lowest_address  <= lowest_address_next;
      any_chunk_seen  <= any_chunk_seen_next;
      size_total      <= size_total_next;
      magic_shift     <= magic_shift_next;
      register_code   <= register_code_next;
    end
  end

endmodule

`default_nettype wire

@@ design/cep_round.sv @@
// Size-rounding unit: rounds the load size up to a multiple of SIZE_ALIGN
// with a multiply by a scaled reciprocal, and forms the summary.
// Depends on cep_pkg.
`default_nettype none

module cep_round #(
  parameter int unsigned SIZE_ALIGN = cep_pkg::SIZE_ALIGN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cep_pkg::sum_req_t  sum_req,
  input  logic               take,
  output logic               busy,
  output logic               done,
  output cep_pkg::out_item_t res
);
  import cep_pkg::*;

  // x = size + SIZE_ALIGN - 1 fits in 33 bits. Its quotient by SIZE_ALIGN is
  // (x * RECIP) >> SH, exact for every 33-bit x. The product is built from the
  // two 17-bit halves of RECIP, and the last step multiplies the quotient back.
  localparam int unsigned XW = ADDR_W + 1;
  localparam int unsigned PW = 2 * XW + 1;
  localparam int unsigned HW = XW + 17;
  localparam int unsigned SH = XW + $clog2(SIZE_ALIGN);
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(SIZE_ALIGN - 1)) / 64'(SIZE_ALIGN);
  localparam logic [16:0] RECIP_LO = RECIP[16:0];
  localparam logic [16:0] RECIP_HI = RECIP[33:17];
  localparam logic [XW-1:0] ALIGN_M1 = XW'(SIZE_ALIGN - 1);
  localparam logic [31:0] ALIGN_W = 32'(SIZE_ALIGN);

  logic [2:0]    stage;
  logic [XW-1:0] x;
  logic [HW-1:0] part_lo, part_hi;
  logic [PW-1:0] prod, quot;
  logic [31:0]   entry, base, size_q;

  assign part_lo = HW'(x) * HW'(RECIP_LO);
  assign part_hi = HW'(x) * HW'(RECIP_HI);
  assign quot    = prod >> SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], sum_req.start};
      if (stage[2]) begin
        done <= 1'b1;
      end else if (take) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_req.start) begin
      x     <= {1'b0, sum_req.size_total} + ALIGN_M1;
      entry <= sum_req.entry_point;
      base  <= sum_req.load_base;
    end
    if (stage[0]) begin
      prod <= PW'(part_lo);
    end else if (stage[1]) begin
      prod <= prod + {part_hi, 17'd0};
    end
    if (stage[2]) begin
      size_q <= quot[31:0] * ALIGN_W;
    end
  end

  assign busy = (|stage) || done;

  always_comb begin
    res               = '0;
    res.kind          = KIND_SUMMARY;
    res.entry_point   = entry;
    res.load_base     = base;
    res.load_size     = size_q;
    res.stack_address = STACK_TOP;
  end

endmodule

`default_nettype wire

@@ design/chunked_executable_parser_unit.sv @@
// Chunked executable parser. Takes one file byte per cycle through an input
// register, parses it in one step and places any data or error result in an
// output register, so a byte is accepted every cycle while the output is free
// or being taken, and its result is offered from the output register once the
// byte has left the input register and been parsed. The end-of-file byte is the
// exception: the summary needs the load size rounded up to SIZE_ALIGN, which a
// reciprocal multiply computes; the summary enters the output register once the
// rounding unit is done and the output is free, and input is held off while the
// rounding unit is busy, which lasts until the summary has been taken.
`default_nettype none

module chunked_executable_parser_unit #(
  parameter int unsigned SIZE_ALIGN = cep_pkg::SIZE_ALIGN_DEF
) (
  input logic      clk,
  input logic      rst,
  cep_in_if.sink   in_chan,
  cep_out_if.source out_chan
);
  import cep_pkg::*;

  logic      in_full;
  in_item_t  in_q;
  logic      out_valid;
  out_item_t out_q;
  logic      out_free, adv;
  logic      par_res_valid;
  out_item_t par_res;
  sum_req_t  sum_req;
  logic      rnd_busy, rnd_done, rnd_take;
  out_item_t rnd_res;

  assign out_free = !out_valid || out_chan.ready;
  assign adv      = in_full && !rnd_busy && out_free;
  assign rnd_take = rnd_done && out_free;

  assign in_chan.ready    = !in_full || adv;
  assign out_chan.valid   = out_valid;
  assign out_chan.payload = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_chan.ready) begin
      in_full <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_q <= in_chan.payload;
    end
  end

  cep_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .item      (in_q),
    .res_valid (par_res_valid),
    .res       (par_res),
    .sum_req   (sum_req)
  );

  cep_round #(.SIZE_ALIGN(SIZE_ALIGN)) u_round (
    .clk     (clk),
    .rst     (rst),
    .sum_req (sum_req),
    .take    (rnd_take),
    .busy    (rnd_busy),
    .done    (rnd_done),
    .res     (rnd_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (par_res_valid || rnd_take) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (par_res_valid) begin
      out_q <= par_res;
    end else if (rnd_take) begin
      out_q <= rnd_res;
    end
  end

  // The rounding unit owns the output path from a summary request until
  // its result has been handed over.
  a_sum_busy: assert property (@(posedge clk) disable iff (rst)
    sum_req.start |=> rnd_busy)
    else $error("rounding unit not busy after a summary request");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(par_res_valid && rnd_take))
    else $error("parser and rounding unit wrote the output together");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (rnd_busy && in_full) |-> !in_chan.ready)
    else $error("input taken while a summary is pending");

  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    rnd_take |=> out_valid && out_q.kind == KIND_SUMMARY)
    else $error("summary not loaded into the output register");

endmodule

`default_nettype wire
